@@ rtl/dxt1_block_decoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// dxt1 assertion macros
// shared property forms for the dxt1 checker
// ----------------------------------------------------------------------------
`ifndef DXT1_BLOCK_DECODER_UNIT_ASSERT_SVH
`define DXT1_BLOCK_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define DXT1_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DXT1_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dxt1_pkg.sv @@
// ----------------------------------------------------------------------------
// dxt1 package
// shared types, constants and palette functions of the dxt1 block decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dxt1_pkg;

	localparam int MAX_BLOCKS  = 1024;
	localparam int CNT_W       = $clog2(MAX_BLOCKS);
	localparam int SIZE_W      = 11;
	localparam int COORD_W     = 12;
	localparam int TEXEL_W     = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [TEXEL_W-1:0] texel_t;
	typedef texel_t [3:0] palette_t;

	typedef struct packed {
		palette_t           palette;
		logic [31:0]        index_bits;
		logic [CNT_W-1:0]   block_column;
		logic [CNT_W-1:0]   block_row;
		logic               last_block;
	} dxt1_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dxt1_qstat_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_W'(MAX_BLOCKS)) begin
			r = SIZE_W'(MAX_BLOCKS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// floor(x / 3) for x below 768 via reciprocal multiply
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	function automatic logic [23:0] expand565(input logic [15:0] w);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = w[15:11];
		g = w[10:5];
		b = w[4:0];
		return {r, r[4:2], g, g[5:4], b, b[4:2]};
	endfunction

	function automatic palette_t build_palette(input logic [15:0] w0, input logic [15:0] w1);
		logic [23:0] c0;
		logic [23:0] c1;
		logic [23:0] m2;
		logic [23:0] m3;
		palette_t    p;
		c0 = expand565(w0);
		c1 = expand565(w1);
		for (int k = 0; k < 3; k++) begin
			if (w0 > w1) begin
				m2[8*k +: 8] = div3({1'b0, c0[8*k +: 8], 1'b0} + 10'(c1[8*k +: 8]));
				m3[8*k +: 8] = div3(10'(c0[8*k +: 8]) + {1'b0, c1[8*k +: 8], 1'b0});
			end else begin
				m2[8*k +: 8] = 8'((9'(c0[8*k +: 8]) + 9'(c1[8*k +: 8])) >> 1);
				m3[8*k +: 8] = 8'h00;
			end
		end
		p[0] = {ALPHA_OPAQUE, c0};
		p[1] = {ALPHA_OPAQUE, c1};
		p[2] = {ALPHA_OPAQUE, m2};
		p[3] = (w0 > w1) ? {ALPHA_OPAQUE, m3} : '0;
		return p;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dxt1_front.sv @@
// ----------------------------------------------------------------------------
// dxt1 front
// accepts blocks, builds the palette and walks the block counters
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_front import dxt1_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [15:0]       color_first,
	input  wire logic [15:0]       color_second,
	input  wire logic [31:0]       index_bits,
	input  wire logic [SIZE_W-1:0] width_blocks,
	input  wire logic [SIZE_W-1:0] height_blocks,
	input  wire dxt1_qstat_t       qstat,
	output logic                   push,
	output dxt1_entry_t            push_entry
);

	logic [CNT_W-1:0]  block_column_q;
	logic [CNT_W-1:0]  block_row_q;
	logic [SIZE_W-1:0] wb;
	logic [SIZE_W-1:0] hb;
	logic              last_col;
	logic              last_row;

	assign wb       = clamp_size(width_blocks);
	assign hb       = clamp_size(height_blocks);
	assign last_col = (SIZE_W'(block_column_q) + SIZE_W'(1)) >= wb;
	assign last_row = (SIZE_W'(block_row_q) + SIZE_W'(1)) >= hb;

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		push_entry.palette      = build_palette(color_first, color_second);
		push_entry.index_bits   = index_bits;
		push_entry.block_column = block_column_q;
		push_entry.block_row    = block_row_q;
		push_entry.last_block   = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_column_q <= '0;
			block_row_q    <= '0;
		end else if (push) begin
			if (last_col) begin
				block_column_q <= '0;
				block_row_q    <= last_row ? '0 : block_row_q + CNT_W'(1);
			end else begin
				block_column_q <= block_column_q + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dxt1_queue.sv @@
// ----------------------------------------------------------------------------
// dxt1 queue
// short fifo of decoded blocks between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_queue import dxt1_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire dxt1_entry_t push_entry,
	input  wire logic        pop,
	output dxt1_entry_t      head,
	output dxt1_qstat_t      qstat
);

	dxt1_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dxt1_back.sv @@
// ----------------------------------------------------------------------------
// dxt1 back
// emits four pixel rows per queued block through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_back import dxt1_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dxt1_entry_t        head,
	input  wire dxt1_qstat_t        qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COORD_W-1:0]      pixel_x,
	output logic [COORD_W-1:0]      pixel_y,
	output logic [TEXEL_W-1:0]      texel_zero,
	output logic [TEXEL_W-1:0]      texel_one,
	output logic [TEXEL_W-1:0]      texel_two,
	output logic [TEXEL_W-1:0]      texel_three,
	output logic                    block_done,
	output logic                    image_done
);

	logic [1:0] row_q;
	logic       out_valid_q;
	logic       emit;
	logic [7:0] row_bits;
	logic       last_row;

	assign emit     = (!out_valid_q || !out_stall) && !qstat.empty;
	assign last_row = (row_q == 2'd3);
	assign pop      = emit && last_row;
	assign row_bits = head.index_bits[8*row_q +: 8];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			row_q       <= row_q + 2'd1;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x     <= {head.block_column, 2'b00};
			pixel_y     <= {head.block_row, row_q};
			texel_zero  <= head.palette[row_bits[1:0]];
			texel_one   <= head.palette[row_bits[3:2]];
			texel_two   <= head.palette[row_bits[5:4]];
			texel_three <= head.palette[row_bits[7:6]];
			block_done  <= last_row;
			image_done  <= last_row && head.last_block;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dxt1_block_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// dxt1 block decoder unit
// the first row of a block passes through the block queue and then the output register
// throughput: row emitter sends one row per cycle while a block is queued and out_stall is low, four rows per block
// the two-entry block queue lets the front accept while rows are still being sent
// reset: block counters and queue clear, sizes return to one block by one block
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_block_decoder_unit import dxt1_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        color_first,
	input  wire logic [15:0]        color_second,
	input  wire logic [31:0]        index_bits,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COORD_W-1:0]      pixel_x,
	output logic [COORD_W-1:0]      pixel_y,
	output logic [TEXEL_W-1:0]      texel_zero,
	output logic [TEXEL_W-1:0]      texel_one,
	output logic [TEXEL_W-1:0]      texel_two,
	output logic [TEXEL_W-1:0]      texel_three,
	output logic                    block_done,
	output logic                    image_done
);

	logic [SIZE_W-1:0] width_blocks_q;
	logic [SIZE_W-1:0] height_blocks_q;
	reg_idx_t          reg_idx;
	logic              cfg_write;
	logic              push;
	logic              pop;
	dxt1_entry_t       push_entry;
	dxt1_entry_t       head;
	dxt1_qstat_t       qstat;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_blocks_q  <= SIZE_W'(1);
			height_blocks_q <= SIZE_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_WIDTH:  width_blocks_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_blocks_q <= pwdata[SIZE_W-1:0];
				default:    width_blocks_q  <= width_blocks_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = 32'(width_blocks_q);
			REG_HEIGHT: prdata = 32'(height_blocks_q);
			default:    prdata = '0;
		endcase
	end

	dxt1_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.color_first   (color_first),
		.color_second  (color_second),
		.index_bits    (index_bits),
		.width_blocks  (width_blocks_q),
		.height_blocks (height_blocks_q),
		.qstat         (qstat),
		.push          (push),
		.push_entry    (push_entry)
	);

	dxt1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	dxt1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.texel_zero  (texel_zero),
		.texel_one   (texel_one),
		.texel_two   (texel_two),
		.texel_three (texel_three),
		.block_done  (block_done),
		.image_done  (image_done)
	);

endmodule

`default_nettype wire

@@ rtl/dxt1_checker.sv @@
// ----------------------------------------------------------------------------
// dxt1 checker
// port-level properties of the dxt1 block decoder unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "dxt1_block_decoder_unit_assert.svh"

module dxt1_checker import dxt1_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	input  wire logic [TEXEL_W-1:0] texel_zero,
	input  wire logic               block_done,
	input  wire logic               image_done
);

	`DXT1_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(texel_zero) && $stable(pixel_y), "stalled output transaction changed")
	`DXT1_ASSERT_NOW(a_image_in_block, out_valid && image_done, block_done, "image end without block end")
	`DXT1_ASSERT_NOW(a_done_row, out_valid, block_done == (pixel_y[1:0] == 2'd3), "block end not on fourth row")
	`DXT1_ASSERT_NOW(a_x_aligned, out_valid, pixel_x[1:0] == 2'd0, "pixel x not block aligned")

endmodule

bind dxt1_block_decoder_unit dxt1_checker u_dxt1_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.texel_zero (texel_zero),
	.block_done (block_done),
	.image_done (image_done)
);

`default_nettype wire

@@ tb/sv/dxt1_block_decoder_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dxt1 block decoder checker
// follows the size registers and the block counters, decodes every accepted
// block into its four rows and compares each delivered row in order
// ----------------------------------------------------------------------------

module dxt1_block_decoder_unit_checker import dxt1_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [15:0]        color_first,
	input  wire logic [15:0]        color_second,
	input  wire logic [31:0]        index_bits,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	input  wire logic [TEXEL_W-1:0] texel_zero,
	input  wire logic [TEXEL_W-1:0] texel_one,
	input  wire logic [TEXEL_W-1:0] texel_two,
	input  wire logic [TEXEL_W-1:0] texel_three,
	input  wire logic               block_done,
	input  wire logic               image_done,
	output int                      fail_count,
	output int                      rows_pending
);

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		texel_t [3:0]       texels;
		logic               last_row_of_block;
		logic               last_row_of_image;
	} pixel_row_t;

	logic [SIZE_W-1:0] width_cfg = SIZE_W'(1);
	logic [SIZE_W-1:0] height_cfg = SIZE_W'(1);
	logic [CNT_W-1:0]  block_col = '0;
	logic [CNT_W-1:0]  block_line = '0;
	pixel_row_t        decoded_rows [$];
	pixel_row_t        next_row;
	pixel_row_t        want_row;
	palette_t          pal;
	texel_t            seen [4];
	logic              end_col;
	logic              end_line;
	int                errors = 0;

	function automatic int unsigned blocks_of(input logic [SIZE_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_BLOCKS)
			return MAX_BLOCKS;
		return v;
	endfunction

	// 5 or 6 bit channel widened to 8 bits by repeating its top bits
	function automatic logic [7:0] widen(input int unsigned v, input int unsigned bits);
		return (v << (8 - bits)) | (v >> (2 * bits - 8));
	endfunction

	function automatic palette_t palette_of(input logic [15:0] w0, input logic [15:0] w1);
		int unsigned e0 [3];
		int unsigned e1 [3];
		logic [23:0] third_a;
		logic [23:0] third_b;
		palette_t    p;
		e0[0] = widen(w0[15:11], 5);
		e0[1] = widen(w0[10:5], 6);
		e0[2] = widen(w0[4:0], 5);
		e1[0] = widen(w1[15:11], 5);
		e1[1] = widen(w1[10:5], 6);
		e1[2] = widen(w1[4:0], 5);
		for (int k = 0; k < 3; k++) begin
			if (w0 > w1) begin
				third_a[8*(2-k) +: 8] = (2 * e0[k] + e1[k]) / 3;
				third_b[8*(2-k) +: 8] = (e0[k] + 2 * e1[k]) / 3;
			end else begin
				third_a[8*(2-k) +: 8] = (e0[k] + e1[k]) / 2;
				third_b[8*(2-k) +: 8] = 8'h00;
			end
		end
		p[0] = {ALPHA_OPAQUE, e0[0][7:0], e0[1][7:0], e0[2][7:0]};
		p[1] = {ALPHA_OPAQUE, e1[0][7:0], e1[1][7:0], e1[2][7:0]};
		p[2] = {ALPHA_OPAQUE, third_a};
		p[3] = (w0 > w1) ? {ALPHA_OPAQUE, third_b} : '0;
		return p;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg = SIZE_W'(1);
			height_cfg = SIZE_W'(1);
			block_col = '0;
			block_line = '0;
			decoded_rows.delete();
			rows_pending <= 0;
			fail_count <= errors;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_WIDTH: width_cfg = pwdata[SIZE_W-1:0];
					REG_HEIGHT: height_cfg = pwdata[SIZE_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				pal = palette_of(color_first, color_second);
				end_col = (block_col + 1) >= blocks_of(width_cfg);
				end_line = (block_line + 1) >= blocks_of(height_cfg);
				for (int r = 0; r < 4; r++) begin
					next_row.px = {block_col, 2'b00};
					next_row.py = {block_line, 2'b00} + COORD_W'(r);
					for (int c = 0; c < 4; c++)
						next_row.texels[c] = pal[index_bits[8*r + 2*c +: 2]];
					next_row.last_row_of_block = (r == 3);
					next_row.last_row_of_image = (r == 3) && end_col && end_line;
					decoded_rows.push_back(next_row);
				end
				if (end_col) begin
					block_col = '0;
					block_line = end_line ? '0 : block_line + 1'b1;
				end else begin
					block_col = block_col + 1'b1;
				end
			end

			if (out_valid && !out_stall) begin
				if (decoded_rows.size() == 0) begin
					errors++;
					$display("%0t row expected none actual x %0d y %0d", $time,
						pixel_x, pixel_y);
				end else begin
					want_row = decoded_rows.pop_front();
					seen = '{texel_zero, texel_one, texel_two, texel_three};
					compare_field("pixel_x", want_row.px, pixel_x);
					compare_field("pixel_y", want_row.py, pixel_y);
					for (int c = 0; c < 4; c++)
						compare_field($sformatf("texel %0d", c), want_row.texels[c], seen[c]);
					compare_field("block_done", want_row.last_row_of_block, block_done);
					compare_field("image_done", want_row.last_row_of_image, image_done);
				end
			end

			rows_pending <= decoded_rows.size();
			fail_count <= errors;
		end
	end

endmodule

@@ tb/sv/tb_dxt1_block_decoder_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dxt1 block decoder testbench
// drives directed and random blocks through several image sizes, including
// zero, oversize and shrunk sizes, with random gaps and stalls on both
// channels; the checker decodes and compares rows
// ----------------------------------------------------------------------------

module tb_dxt1_block_decoder_unit;
	import dxt1_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        color_first = '0;
	logic [15:0]        color_second = '0;
	logic [31:0]        index_bits = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [TEXEL_W-1:0] texel_zero;
	logic [TEXEL_W-1:0] texel_one;
	logic [TEXEL_W-1:0] texel_two;
	logic [TEXEL_W-1:0] texel_three;
	logic               block_done;
	logic               image_done;
	int                 fail_count;
	int                 rows_pending;
	int                 cycle_count = 0;
	int                 stall_left = 0;
	int                 hold;
	bit                 tx_quiet = 1'b0;
	bit                 rx_quiet = 1'b0;

	dxt1_block_decoder_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.color_first  (color_first),
		.color_second (color_second),
		.index_bits   (index_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.texel_zero   (texel_zero),
		.texel_one    (texel_one),
		.texel_two    (texel_two),
		.texel_three  (texel_three),
		.block_done   (block_done),
		.image_done   (image_done)
	);

	dxt1_block_decoder_unit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.color_first  (color_first),
		.color_second (color_second),
		.index_bits   (index_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.texel_zero   (texel_zero),
		.texel_one    (texel_one),
		.texel_two    (texel_two),
		.texel_three  (texel_three),
		.block_done   (block_done),
		.image_done   (image_done),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("dxt1_block_decoder_unit: mismatch");
			$finish;
		end
	end

	// row receiver: a fresh stall length after every accepted transaction
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold = rx_quiet ? 0 : $urandom_range(0, 15);
			stall_left <= hold;
			out_stall <= (hold != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
			input logic [31:0] idx);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		color_first <= c0;
		color_second <= c1;
		index_bits <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random_block();
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] t;
		int          kind;
		kind = $urandom_range(0, 9);
		a = $urandom;
		b = $urandom;
		case (kind)
			0: b = a;
			1: begin
				a = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
				b = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			end
			2, 3, 4, 5: if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			6, 7, 8: if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			default: ;
		endcase
		send_block(a, b, $urandom);
	endtask

	task automatic write_size(input reg_idx_t which, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one block images at reset size, both palette modes and the edges
		send_block(16'hffff, 16'h0000, 32'he4e4e4e4);
		send_block(16'h0000, 16'hffff, 32'he4e4e4e4);
		send_block(16'h8410, 16'h8410, 32'h1b1b1b1b);
		send_block(16'hf800, 16'h07e0, 32'h00ff55aa);
		send_block(16'h07e0, 16'hf800, 32'hffffffff);
		send_block(16'h001f, 16'h001e, 32'h00000000);
		send_block(16'h0001, 16'h0000, 32'h39c6e4a5);
		send_block(16'h0000, 16'h0000, 32'hffffffff);
		send_block(16'hffff, 16'hffff, 32'haaaaaaaa);
		send_block(16'h7bef, 16'h8410, 32'h93e4b1d8);
		send_block(16'hffdf, 16'h0020, 32'h55555555);
		send_block(16'h8000, 16'h7fff, 32'hc6391b4e);

		// zero sizes count as one block
		settle();
		write_size(REG_WIDTH, 32'h0000_0000);
		write_size(REG_HEIGHT, 32'hffff_f800);
		repeat (3) send_random_block();

		// small image wrapping twice, upper write bits ignored
		settle();
		write_size(REG_WIDTH, 32'hffff_f803);
		write_size(REG_HEIGHT, 32'h0000_0002);
		repeat (14) send_random_block();

		// image shrunk while the counters sit past the new end
		settle();
		write_size(REG_WIDTH, 32'd8);
		write_size(REG_HEIGHT, 32'd8);
		repeat (21) send_random_block();
		settle();
		write_size(REG_WIDTH, 32'd2);
		write_size(REG_HEIGHT, 32'd2);
		repeat (6) send_random_block();

		// oversize height in one column, then a wide single row
		settle();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		write_size(REG_WIDTH, 32'd1);
		write_size(REG_HEIGHT, 32'd2047);
		repeat (40) send_random_block();
		settle();
		write_size(REG_WIDTH, 32'd1024);
		write_size(REG_HEIGHT, 32'd1);
		repeat (40) send_random_block();

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			write_size(REG_WIDTH, ($urandom << SIZE_W) | $urandom_range(0, 6));
			write_size(REG_HEIGHT, ($urandom << SIZE_W) | $urandom_range(0, 5));
			repeat (25) send_random_block();
		end

		settle();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("dxt1_block_decoder_unit: match");
		end else begin
			$display("dxt1_block_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule
